>>> hw/rtl/lifo_pkg.sv
// Shared types and codes of the LIFO stack with in-place update.
`default_nettype none

package lifo_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned FuncW     = 2;
    localparam int unsigned PosW      = 8;
    localparam int unsigned OutCountW = 8;

    typedef enum logic [FuncW-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADPOS    = 2'd3
    } status_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/lifo_stack_with_update.sv
// Top level of the LIFO stack with in-place update, built as a chain of shifting cells.
// Timing: a command's result is strobed in the cycle after start is accepted.
// Throughput: one command per cycle; busy stays low since every command completes in
// the cell chain, whose top cell always holds the top of the stack.
// Reset: rst_n clears the entry count and the result strobe; cell contents are left as
// they are and no clearing pass is needed. The receiver cannot stall the result beat.
`default_nettype none

module lifo_stack_with_update
    import lifo_pkg::*;
#(
    parameter int unsigned DEPTH = 128
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [FuncW-1:0]        func,
    input  wire logic signed [WordW-1:0] value,
    input  wire logic [PosW-1:0]         position,
    output logic                         strobe,
    output logic signed [WordW-1:0]      data,
    output logic [1:0]                   status,
    output logic [OutCountW-1:0]         count,
    output logic                         empty_res,
    output logic                         full_res
);

    // Width of the entry count, which must be able to hold DEPTH itself.
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    // Width used when comparing the position against the count.
    localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             strobe_reg;
    logic [WordW-1:0] data_reg;
    logic [WordW-1:0] data_next;
    status_t          status_reg;
    status_t          status_next;

    logic             accept;
    op_t              op;
    logic             is_empty;
    logic             is_full;
    logic             pos_ok;
    logic             do_change;
    cell_ctl_t        ctl;
    logic [CmpW-1:0]  pos_ext;
    logic [CmpW-1:0]  cnt_ext;

    // Cell 0 is always the top of the stack, cell DEPTH-1 the bottom.
    logic [WordW-1:0] cell_word [DEPTH];
    logic [DEPTH-1:0] wr_sel;

    // Every command completes in the cycle it is accepted, so the block is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = op_t'(func);

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CntW'(DEPTH));

    // A change position is valid when it lies between 1 and the current count.
    assign pos_ext   = CmpW'(position);
    assign cnt_ext   = CmpW'(count_reg);
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign do_change = accept && (op == OP_CHANGE) && pos_ok;

    // Decode the command into shift commands for the chain, the new count and the result.
    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        data_next   = '0;
        status_next = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ctl.push   = accept;
                    count_next = count_reg + CntW'(1);
                end
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    status_next = ST_UNDERFLOW;
                    data_next   = '1;
                end
                else
                begin
                    ctl.pop    = accept;
                    data_next  = cell_word[0];
                    count_next = count_reg - CntW'(1);
                end
            end
            OP_PEEK:
            begin
                if (is_empty)
                begin
                    status_next = ST_UNDERFLOW;
                    data_next   = '1;
                end
                else
                begin
                    data_next = cell_word[0];
                end
            end
            OP_CHANGE:
            begin
                if (!pos_ok)
                begin
                    status_next = ST_BADPOS;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // The row of cells: each takes its upper neighbour on push and its lower on pop.
    // A change lands in the cell whose depth from the top matches the position.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WordW-1:0] above_word;
        logic [WordW-1:0] below_word;

        assign wr_sel[i] = do_change && (pos_ext == CmpW'(i + 1));

        if (i == 0)
        begin : g_top
            assign above_word = value;
        end
        else
        begin : g_mid
            assign above_word = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign below_word = '0;
        end
        else
        begin : g_inner
            assign below_word = cell_word[i+1];
        end

        lifo_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .wr_sel   (wr_sel[i]),
            .above    (above_word),
            .below    (below_word),
            .new_word (value),
            .word     (cell_word[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload is captured with the accepted command and shown with the strobe.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    // The count register already holds the post-command count when the strobe is high.
    assign strobe    = strobe_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign count     = OutCountW'(count_reg);
    assign empty_res = is_empty;
    assign full_res  = is_full;

endmodule

`default_nettype wire

>>> hw/rtl/lifo_cell.sv
// One storage cell of the stack chain: shifts down on push, up on pop, and takes a new word when selected.
`default_nettype none

module lifo_cell
    import lifo_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic             wr_sel,
    input  wire logic [WordW-1:0] above,
    input  wire logic [WordW-1:0] below,
    input  wire logic [WordW-1:0] new_word,
    output logic      [WordW-1:0] word
);

    logic [WordW-1:0] word_reg;
    logic [WordW-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.push)
        begin
            word_next = above;
        end
        else if (ctl.pop)
        begin
            word_next = below;
        end
        else if (wr_sel)
        begin
            word_next = new_word;
        end
    end

    // Payload only: an entry is never read before it has been written.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire
